// ===== hw/rtl/scbl_pkg.sv =====
// size class bin lookup: shared widths, codes, state and status types
// no dependencies
`timescale 1ns / 1ps

package scbl_pkg;

   localparam int REQ_W        = 32;
   localparam int SIZE_W       = 26;
   localparam int IDX_OUT_W    = 7;
   localparam int LIN_W        = 16;
   localparam int MGD_W        = 24;
   localparam int RATIO_W      = 14;
   localparam int RATIO_FRAC   = 12;
   localparam int PROD_W       = SIZE_W + RATIO_W;
   localparam int QUOT_W       = PROD_W - RATIO_FRAC;
   localparam int ALIGNED_W    = QUOT_W + 1;
   localparam int ALIGN_BYTES  = 8;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_MAX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MANAGED_MAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH_RATIO = 2'd2;

   localparam logic [LIN_W-1:0]   LINEAR_MAX_RST   = 16'd128;
   localparam logic [MGD_W-1:0]   MANAGED_MAX_RST  = 24'd4096;
   localparam logic [RATIO_W-1:0] GROWTH_RATIO_RST = 14'd4506;

   typedef enum logic [2:0] {
      B_INIT,
      B_LIN,
      B_MUL,
      B_GEO,
      B_DONE
   } build_state_type;

   typedef enum logic [0:0] {
      S_IDLE,
      S_PROBE
   } search_state_type;

   typedef struct packed {
      logic              busy;
      logic [SIZE_W-1:0] last_size;
   } build_stat_type;

endpackage

// ===== hw/rtl/scbl_table.sv =====
// size class bin lookup: bin size memory, one write and one registered read port
// depends on scbl_pkg
`timescale 1ns / 1ps

module scbl_table #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [scbl_pkg::SIZE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [scbl_pkg::SIZE_W-1:0] rd_data
);
   import scbl_pkg::*;

   logic [SIZE_W-1:0] mem [DEPTH];
   logic [SIZE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/scbl_builder.sv =====
// size class bin lookup: sequencer that fills the bin table from the configuration
// depends on scbl_pkg
`timescale 1ns / 1ps

module scbl_builder #(
   parameter int MAX_BINS = 64,
   parameter int IDX_W    = 6,
   parameter int CNT_W    = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [scbl_pkg::LIN_W-1:0]    linear_max,
   input  logic [scbl_pkg::MGD_W-1:0]    managed_max,
   input  logic [scbl_pkg::RATIO_W-1:0]  growth_ratio,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [scbl_pkg::SIZE_W-1:0]   wr_data,
   output logic [CNT_W-1:0]              bin_count,
   output scbl_pkg::build_stat_type      stat
);
   import scbl_pkg::*;

   build_state_type    state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SIZE_W-1:0]  val_ff, val_in;
   logic [SIZE_W-1:0]  prev_ff, prev_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic [CNT_W-1:0]     cnt_inc;
   logic [SIZE_W-1:0]    val_inc;
   logic [QUOT_W-1:0]    quot;
   logic [ALIGNED_W-1:0] aligned;
   logic [ALIGNED_W-1:0] grown;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_INIT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      prev_ff <= prev_in;
      prod_ff <= prod_in;
   end

   assign cnt_inc = cnt_ff + CNT_W'(1);
   assign val_inc = val_ff + SIZE_W'(ALIGN_BYTES);

   // floor of the q28.12 product, rounded up to the alignment
   assign quot    = prod_ff[PROD_W-1:RATIO_FRAC];
   assign aligned = (ALIGNED_W'(quot) + ALIGNED_W'(ALIGN_BYTES - 1))
                    & ~ALIGNED_W'(ALIGN_BYTES - 1);
   // a step that does not grow is pushed up by one alignment unit
   assign grown   = (aligned <= ALIGNED_W'(prev_ff))
                    ? ALIGNED_W'(prev_ff) + ALIGNED_W'(ALIGN_BYTES) : aligned;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      prev_in  = prev_ff;
      prod_in  = prod_ff;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff[IDX_W-1:0];
      wr_data  = val_ff;
      case (state_ff)
         B_INIT: begin
            cnt_in   = '0;
            val_in   = SIZE_W'(ALIGN_BYTES);
            state_in = B_LIN;
         end
         B_LIN: begin
            // first bin is always written, even for a tiny linear_max
            wr_en   = 1'b1;
            prev_in = val_ff;
            cnt_in  = cnt_inc;
            val_in  = val_inc;
            if (cnt_inc < CNT_W'(MAX_BINS) && val_inc <= SIZE_W'(linear_max)) begin
               state_in = B_LIN;
            end else begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            if (cnt_ff < CNT_W'(MAX_BINS) && prev_ff < SIZE_W'(managed_max)) begin
               prod_in  = PROD_W'(prev_ff) * PROD_W'(growth_ratio);
               state_in = B_GEO;
            end else begin
               state_in = B_DONE;
            end
         end
         B_GEO: begin
            wr_en    = 1'b1;
            wr_data  = grown[SIZE_W-1:0];
            prev_in  = grown[SIZE_W-1:0];
            cnt_in   = cnt_inc;
            state_in = B_MUL;
         end
         B_DONE: begin
            state_in = B_DONE;
         end
         default: begin
            state_in = B_INIT;
         end
      endcase
      if (restart) begin
         state_in = B_INIT;
      end
   end

   assign bin_count      = cnt_ff;
   assign stat.busy      = (state_ff != B_DONE);
   assign stat.last_size = prev_ff;

endmodule

// ===== hw/rtl/scbl_search.sv =====
// size class bin lookup: binary search over the bin table, one probe per cycle
// depends on scbl_pkg
`timescale 1ns / 1ps

module scbl_search #(
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [scbl_pkg::REQ_W-1:0]       req_size,
   input  logic [CNT_W-1:0]                 bin_count,
   input  logic [scbl_pkg::SIZE_W-1:0]      last_size,
   output logic                             rd_en,
   output logic [IDX_W-1:0]                 rd_addr,
   input  logic [scbl_pkg::SIZE_W-1:0]      rd_data,
   output logic                             busy,
   output logic                             rsp_strobe,
   output logic [scbl_pkg::IDX_OUT_W-1:0]   rsp_bin_index,
   output logic                             rsp_managed,
   output logic [scbl_pkg::SIZE_W-1:0]      rsp_bin_size
);
   import scbl_pkg::*;

   search_state_type   state_ff, state_in;
   logic [REQ_W-1:0]   req_ff, req_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [SIZE_W-1:0]  hi_size_ff, hi_size_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic               strobe_ff, strobe_in;
   logic [IDX_OUT_W-1:0] index_ff, index_in;
   logic               managed_ff, managed_in;
   logic [SIZE_W-1:0]  size_ff, size_in;

   logic [CNT_W-1:0]   last_cnt;
   logic [IDX_W-1:0]   last_idx;
   logic [31:0]        count_wide;
   logic [31:0]        lo_wide;
   logic [IDX_W:0]     mid_sum;

   assign last_cnt   = bin_count - CNT_W'(1);
   assign last_idx   = last_cnt[IDX_W-1:0];
   assign count_wide = 32'(bin_count);
   assign lo_wide    = 32'(lo_in);
   assign mid_sum    = (IDX_W + 1)'(lo_in) + (IDX_W + 1)'(hi_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      hi_size_ff <= hi_size_in;
      mid_ff     <= mid_in;
      index_ff   <= index_in;
      managed_ff <= managed_in;
      size_ff    <= size_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      hi_size_in = hi_size_ff;
      mid_in     = mid_ff;
      strobe_in  = 1'b0;
      index_in   = index_ff;
      managed_in = managed_ff;
      size_in    = size_ff;
      rd_en      = 1'b0;
      rd_addr    = mid_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_size;
               lo_in      = IDX_W'(1);
               hi_in      = last_idx;
               hi_size_in = last_size;
            end
         end
         S_PROBE: begin
            // hi always points at an entry no smaller than the request
            if (REQ_W'(rd_data) >= req_ff) begin
               hi_in      = mid_ff;
               hi_size_in = rd_data;
            end else begin
               lo_in = mid_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_ff == S_IDLE && start && req_size <= REQ_W'(ALIGN_BYTES)) begin
         // at or below the first bin
         strobe_in  = 1'b1;
         index_in   = '0;
         managed_in = 1'b1;
         size_in    = SIZE_W'(ALIGN_BYTES);
      end else if (state_ff == S_IDLE && start && req_size >= REQ_W'(last_size)) begin
         strobe_in  = 1'b1;
         index_in   = count_wide[IDX_OUT_W-1:0];
         managed_in = 1'b0;
         size_in    = '0;
      end else if ((state_ff == S_IDLE && start) || state_ff == S_PROBE) begin
         if (lo_in == hi_in) begin
            strobe_in  = 1'b1;
            index_in   = lo_wide[IDX_OUT_W-1:0];
            managed_in = 1'b1;
            size_in    = hi_size_in;
            state_in   = S_IDLE;
         end else begin
            mid_in   = mid_sum[IDX_W:1];
            rd_en    = 1'b1;
            rd_addr  = mid_sum[IDX_W:1];
            state_in = S_PROBE;
         end
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_bin_index = index_ff;
   assign rsp_managed   = managed_ff;
   assign rsp_bin_size  = size_ff;

endmodule

// ===== hw/rtl/size_class_bin_lookup.sv =====
// size class bin lookup: top level with configuration registers, builder,
// bin table memory and search unit; depends on scbl_pkg, scbl_table,
// scbl_builder and scbl_search
//
// channel   ports                                   transfer
// request   start, busy, req_request_size           start high while busy low
// response  rsp_strobe, rsp_bin_index, rsp_managed,  one cycle at rsp_strobe
//           rsp_bin_size
// config    csr_write_enable, csr_index,            any edge with write enable
//           csr_write_data
//
// a request at or below the first bin or at or above the last bin answers in the
// cycle after it is taken; otherwise after one table read per halving of the
// search range, at most ceil(log2(MAX_BINS)) reads on the single read port
// the table is rebuilt after reset and after every write to a defined register
// (index 0 to 2): a start step, a write per linear bin, a multiply and then an
// align-and-write per geometric bin, and a final check; busy stays high meanwhile
// the response cannot be stalled; the next request is taken while it is shown
`timescale 1ns / 1ps

module size_class_bin_lookup #(
   parameter int MAX_BINS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [scbl_pkg::REQ_W-1:0]         req_request_size,
   output logic                               rsp_strobe,
   output logic [scbl_pkg::IDX_OUT_W-1:0]     rsp_bin_index,
   output logic                               rsp_managed,
   output logic [scbl_pkg::SIZE_W-1:0]        rsp_bin_size,
   input  logic                               csr_write_enable,
   input  logic [scbl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scbl_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import scbl_pkg::*;

   localparam int IDX_W = $clog2(MAX_BINS);
   localparam int CNT_W = $clog2(MAX_BINS + 1);

   logic [LIN_W-1:0]   linear_max_ff, linear_max_in;
   logic [MGD_W-1:0]   managed_max_ff, managed_max_in;
   logic [RATIO_W-1:0] growth_ratio_ff, growth_ratio_in;
   logic               restart;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [SIZE_W-1:0]  wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [SIZE_W-1:0]  rd_data;
   logic [CNT_W-1:0]   bin_count;
   build_stat_type     build_stat;
   logic               search_busy;
   logic               accept;

   always_comb begin
      linear_max_in   = linear_max_ff;
      managed_max_in  = managed_max_ff;
      growth_ratio_in = growth_ratio_ff;
      restart         = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LINEAR_MAX: begin
               linear_max_in = csr_write_data[LIN_W-1:0];
               restart       = 1'b1;
            end
            CSR_MANAGED_MAX: begin
               managed_max_in = csr_write_data[MGD_W-1:0];
               restart        = 1'b1;
            end
            CSR_GROWTH_RATIO: begin
               growth_ratio_in = csr_write_data[RATIO_W-1:0];
               restart         = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_max_ff   <= LINEAR_MAX_RST;
         managed_max_ff  <= MANAGED_MAX_RST;
         growth_ratio_ff <= GROWTH_RATIO_RST;
      end else begin
         linear_max_ff   <= linear_max_in;
         managed_max_ff  <= managed_max_in;
         growth_ratio_ff <= growth_ratio_in;
      end
   end

   scbl_builder #(
      .MAX_BINS (MAX_BINS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_builder (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .linear_max   (linear_max_ff),
      .managed_max  (managed_max_ff),
      .growth_ratio (growth_ratio_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .bin_count    (bin_count),
      .stat         (build_stat)
   );

   scbl_table #(
      .DEPTH  (MAX_BINS),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = build_stat.busy | search_busy;
   assign accept = start & ~busy;

   scbl_search #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_search (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .req_size      (req_request_size),
      .bin_count     (bin_count),
      .last_size     (build_stat.last_size),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .busy          (search_busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_bin_index (rsp_bin_index),
      .rsp_managed   (rsp_managed),
      .rsp_bin_size  (rsp_bin_size)
   );

endmodule

// ===== tb/tb_size_class_bin_lookup.sv =====
// testbench for size_class_bin_lookup: a directed table of requests and
// register writes, then random configuration phases, checked against the expected
// values in the table or a behavioural copy of the bin table; depends on scbl_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_size_class_bin_lookup;
   import scbl_pkg::*;

   localparam int MAX_BINS    = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_PHASES    = 14;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] index;
      logic                 managed;
      logic [SIZE_W-1:0]    size;
   } bin_resp_type;

   typedef enum logic { ROW_CSR, ROW_REQ } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] data;
      logic [REQ_W-1:0]      size;
      bit                    typed;
      bin_resp_type          want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [REQ_W-1:0]      req_request_size = '0;
   logic                  rsp_strobe;
   logic [IDX_OUT_W-1:0]  rsp_bin_index;
   logic                  rsp_managed;
   logic [SIZE_W-1:0]     rsp_bin_size;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // behavioural copy of the configuration and the bin table
   logic [LIN_W-1:0]      lin_cfg;
   logic [MGD_W-1:0]      mgd_cfg;
   logic [RATIO_W-1:0]    ratio_cfg;
   logic [SIZE_W-1:0]     bin_sizes [MAX_BINS];
   int unsigned           bin_total;

   bin_resp_type          due_q [$];
   dir_row_type           dir_rows [$];
   bit                    no_idle = 1'b0;
   int unsigned           cycles = 0;
   int unsigned           n_bad = 0;
   int unsigned           n_resp = 0;
   int unsigned           n_unmanaged = 0;
   int unsigned           n_req = 0;
   int unsigned           n_wr = 0;

   size_class_bin_lookup #(
      .MAX_BINS(MAX_BINS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_request_size(req_request_size),
      .rsp_strobe(rsp_strobe),
      .rsp_bin_index(rsp_bin_index),
      .rsp_managed(rsp_managed),
      .rsp_bin_size(rsp_bin_size),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void rebuild_bins();
      longint unsigned nlin;
      longint unsigned prev;
      longint unsigned nxt;
      int unsigned     n;
      for (int i = 0; i < MAX_BINS; i++) bin_sizes[i] = '0;
      nlin = 64'(lin_cfg / ALIGN_BYTES);
      if (nlin == 0) nlin = 1;
      n = 0;
      while (n < MAX_BINS && n < nlin) begin
         bin_sizes[n] = SIZE_W'((n + 1) * ALIGN_BYTES);
         n++;
      end
      prev = 64'(bin_sizes[n - 1]);
      while (n < MAX_BINS && prev < mgd_cfg) begin
         nxt = (prev * 64'(ratio_cfg)) >> RATIO_FRAC;
         nxt = ((nxt + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
         // a step that does not grow is pushed up by one alignment unit
         if (nxt <= prev) nxt = prev + ALIGN_BYTES;
         nxt = nxt & 64'h3FF_FFFF;
         bin_sizes[n] = nxt[SIZE_W-1:0];
         prev = nxt;
         n++;
      end
      bin_total = n;
   endfunction

   function automatic bin_resp_type lookup_bin(input logic [REQ_W-1:0] sz);
      bin_resp_type r;
      int unsigned  idx;
      int unsigned  last;
      last = bin_total - 1;
      if (sz <= bin_sizes[0]) begin
         idx = 0;
      end else if (sz >= bin_sizes[last]) begin
         idx = bin_total;
      end else begin
         idx = 1;
         while (idx < last && bin_sizes[idx] < sz) idx++;
      end
      r.index = IDX_OUT_W'(idx);
      if (idx < bin_total) begin
         r.managed = 1'b1;
         r.size    = bin_sizes[idx];
      end else begin
         r.managed = 1'b0;
         r.size    = '0;
      end
      return r;
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void dir_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      dir_row_type row;
      row.kind    = ROW_CSR;
      row.reg_idx = idx;
      row.data    = data;
      row.size    = '0;
      row.typed   = 1'b0;
      row.want    = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic void dir_req(input logic [REQ_W-1:0] sz, input bit typed,
                                   input int unsigned idx, input bit mgd,
                                   input int unsigned bsz);
      dir_row_type row;
      row.kind          = ROW_REQ;
      row.reg_idx       = CSR_LINEAR_MAX;
      row.data          = '0;
      row.size          = sz;
      row.typed         = typed;
      row.want.index    = IDX_OUT_W'(idx);
      row.want.managed  = mgd;
      row.want.size     = SIZE_W'(bsz);
      dir_rows.push_back(row);
   endfunction

   // entered and left at a falling edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      int k;
      start = 1'b0;
      while (due_q.size() != 0 || busy) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(posedge clock);
      case (idx)
         CSR_LINEAR_MAX:   lin_cfg   = data[LIN_W-1:0];
         CSR_MANAGED_MAX:  mgd_cfg   = data[MGD_W-1:0];
         CSR_GROWTH_RATIO: ratio_cfg = data[RATIO_W-1:0];
         default: ;
      endcase
      rebuild_bins();
      n_wr++;
      @(negedge clock);
      csr_write_enable = 1'b0;
      // the table rebuild raises busy; let it finish before the next request
      for (k = 0; k < 4 && !busy; k++) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   // entered and left at a falling edge
   task automatic send_request(input logic [REQ_W-1:0] sz, input bit typed,
                               input bin_resp_type want);
      int unsigned g;
      start            = 1'b1;
      req_request_size = sz;
      @(posedge clock);
      while (busy) @(posedge clock);
      due_q.push_back(typed ? want : lookup_bin(sz));
      n_req++;
      @(negedge clock);
      g = gap_len();
      if (g != 0) begin
         start = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      bin_resp_type got;
      bin_resp_type want;
      got = {rsp_bin_index, rsp_managed, rsp_bin_size};
      if (!reset && rsp_strobe) begin
         n_resp++;
         if (!rsp_managed) n_unmanaged++;
         if (due_q.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
               $display("cycle %0d: response with nothing pending: index %0d managed %0b size %0d",
                        cycles, got.index, got.managed, got.size);
         end else begin
            want = due_q.pop_front();
            if (got !== want) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("cycle %0d: expected index %0d managed %0b size %0d, got index %0d managed %0b size %0d",
                           cycles, want.index, want.managed, want.size,
                           got.index, got.managed, got.size);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, due_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned       phase;
      int unsigned       items;
      int unsigned       i;
      int unsigned       k;
      logic [REQ_W-1:0]  sz;
      logic [LIN_W-1:0]  lv;
      logic [MGD_W-1:0]  mv;
      logic [RATIO_W-1:0] rv;
      bin_resp_type      none;

      none      = '0;
      lin_cfg   = LINEAR_MAX_RST;
      mgd_cfg   = MANAGED_MAX_RST;
      ratio_cfg = GROWTH_RATIO_RST;
      rebuild_bins();

      // reset table: 8..128 in steps of 8, then geometric bins from 144
      dir_req(32'd0, 1, 0, 1, 8);
      dir_req(32'd8, 1, 0, 1, 8);
      dir_req(32'd9, 1, 1, 1, 16);
      dir_req(32'd128, 1, 15, 1, 128);
      dir_req(32'hFFFF_FFFF, 0, 0, 0, 0);
      // unit ratio never grows, so each step is forced up by one alignment
      dir_csr(CSR_GROWTH_RATIO, 24'd4096);
      dir_req(32'd200, 0, 0, 0, 0);
      // linear bins only; a request equal to the last bin is unmanaged
      dir_csr(CSR_MANAGED_MAX, 24'd0);
      dir_req(32'd128, 1, 16, 0, 0);
      dir_req(32'd121, 1, 15, 1, 128);
      // tiny linear region leaves a single bin of one alignment unit
      dir_csr(CSR_LINEAR_MAX, 24'd0);
      dir_req(32'd9, 1, 1, 0, 0);
      dir_req(32'd0, 1, 0, 1, 8);
      // full table of linear bins, count saturates
      dir_csr(CSR_LINEAR_MAX, 24'h00FFFF);
      dir_req(32'd512, 1, 64, 0, 0);
      dir_req(32'd511, 1, 63, 1, 512);
      dir_csr(CSR_LINEAR_MAX, 24'd8);
      dir_csr(CSR_MANAGED_MAX, 24'hFF_FFFF);
      dir_csr(CSR_GROWTH_RATIO, 24'd16383);
      dir_req(32'hFFFF_FFFF, 0, 0, 0, 0);
      dir_req(32'd1000, 0, 0, 0, 0);
      dir_csr(CSR_GROWTH_RATIO, 24'd0);
      dir_req(32'd300, 0, 0, 0, 0);
      dir_csr(CSR_GROWTH_RATIO, 24'd4097);
      dir_req(32'h00FF_FFFF, 0, 0, 0, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[j]) begin
         if (dir_rows[j].kind == ROW_CSR)
            write_reg(dir_rows[j].reg_idx, dir_rows[j].data);
         else
            send_request(dir_rows[j].size, dir_rows[j].typed, dir_rows[j].want);
      end

      for (phase = 0; phase < N_PHASES; phase++) begin
         no_idle = (phase % 4 == 3);
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
               0: lv = LIN_W'($urandom_range(0, 7));
               1: lv = 16'd8;
               2: lv = LIN_W'(8 * $urandom_range(1, 64));
               3: lv = LIN_W'($urandom_range(8, 600));
               4: lv = LIN_W'($urandom_range(0, 65535));
               default: lv = 16'hFFFF;
            endcase
            // upper data bits are beyond the register and must be ignored
            write_reg(CSR_LINEAR_MAX, {8'($urandom_range(0, 255)), lv});
         end
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 4))
               0: mv = '0;
               1: mv = MGD_W'($urandom_range(1, 64));
               2: mv = MGD_W'($urandom_range(64, 8192));
               3: mv = MGD_W'($urandom_range(0, 24'hFF_FFFF));
               default: mv = 24'hFF_FFFF;
            endcase
            write_reg(CSR_MANAGED_MAX, mv);
         end
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
               0: rv = RATIO_W'($urandom_range(0, 4096));
               1: rv = 14'd4096;
               2: rv = 14'd4097;
               3: rv = RATIO_W'($urandom_range(4097, 8192));
               4: rv = RATIO_W'($urandom_range(0, 16383));
               default: rv = 14'd16383;
            endcase
            write_reg(CSR_GROWTH_RATIO, {10'($urandom_range(0, 1023)), rv});
         end

         items = $urandom_range(90, 105);
         for (i = 0; i < items; i++) begin
            k = $urandom_range(0, bin_total - 1);
            case ($urandom_range(0, 9))
               0, 1: sz = REQ_W'(bin_sizes[k]) - 32'd1;
               2, 3: sz = REQ_W'(bin_sizes[k]);
               4, 5: sz = REQ_W'(bin_sizes[k]) + 32'd1;
               6, 7: sz = $urandom_range(0, bin_sizes[bin_total - 1] + 16);
               8: sz = $urandom();
               default: sz = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
            endcase
            send_request(sz, 1'b0, none);
         end
      end

      start = 1'b0;
      while (due_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("ran %0d requests (%0d responses, %0d unmanaged) across %0d register writes",
               n_req, n_resp, n_unmanaged, n_wr);
      $display("directed rows %0d, random phases %0d, mismatches %0d",
               dir_rows.size(), N_PHASES, n_bad);
      if (n_bad == 0 && due_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
